// ===== rtl/c6502_pkg.sv =====
package c6502_pkg;

  localparam logic [15:0] RAM_TOP  = 16'h1FFF;
  localparam logic [15:0] ROM_BASE = 16'h8000;
  localparam logic [15:0] VEC_LO   = 16'hFFFC;
  localparam logic [15:0] VEC_HI   = 16'hFFFD;

  localparam logic [7:0] OP_HLT     = 8'h02;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_STX_ZP  = 8'h86;
  localparam logic [7:0] OP_STY_ZP  = 8'h84;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_STX_ABS = 8'h8E;
  localparam logic [7:0] OP_STY_ABS = 8'h8C;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_RESET = 2'd1,
    FUNC_EXEC  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_UNKNOWN_OP = 3'd1,
    STAT_ROM_WR     = 3'd2,
    STAT_UNMAPPED   = 3'd3,
    STAT_HALTED     = 3'd4
  } stat_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_VEC_LO,
    S_VEC_HI,
    S_OPCODE,
    S_OPER1,
    S_OPER2,
    S_DATA,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ADDR_PC,
    ADDR_VEC_LO,
    ADDR_VEC_HI,
    ADDR_ZP,
    ADDR_ABS
  } addr_sel_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_X,
    SEL_Y
  } reg_sel_t;

  typedef struct packed {
    logic       clear_step;
    logic       rom_load;
    logic       mem_rd;
    logic       mem_wr;
    addr_sel_t  addr_sel;
    reg_sel_t   reg_sel;
    logic       reg_load;
    logic       pc_inc;
    logic       pc_load_vec;
    logic       op_capture;
    logic       lo_capture;
    logic       halt_set;
    logic       halt_clr;
    logic       status_wr;
    stat_code_t status_code;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       halted;
    logic [7:0] rd_data;
    logic [7:0] opcode;
  } dp_stat_t;

endpackage

// ===== rtl/c6502_dp.sv =====
module c6502_dp #(
  parameter int RAM_DEPTH = 2048,
  parameter int ROM_DEPTH = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  c6502_pkg::dp_cmd_t cmd,
  output c6502_pkg::dp_stat_t stat,
  input  logic [14:0]        load_address,
  input  logic [7:0]         load_data,
  output logic [15:0]        program_counter,
  output logic [7:0]         accumulator,
  output logic [7:0]         index_x,
  output logic [7:0]         index_y,
  output logic               halted,
  output logic [2:0]         status,
  output logic [7:0]         last_opcode
);
  import c6502_pkg::*;

  localparam int RAM_AW = $clog2(RAM_DEPTH);
  localparam int ROM_AW = $clog2(ROM_DEPTH);

  logic [7:0] ram [RAM_DEPTH];
  logic [7:0] rom [ROM_DEPTH];

  logic [15:0]       pc;
  logic [7:0]        acc;
  logic [7:0]        xr;
  logic [7:0]        yr;
  logic              halt;
  logic [7:0]        opcode;
  logic [7:0]        op_lo;
  stat_code_t        stat_code;
  logic [RAM_AW-1:0] clr_addr;
  logic [7:0]        ram_q;
  logic [7:0]        rom_q;
  logic              q_is_ram;
  logic              q_is_rom;

  logic [15:0] addr;
  logic        addr_ram;
  logic        addr_rom;
  logic [7:0]  rd_data;
  logic [7:0]  wr_data;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_PC:     addr = pc;
      ADDR_VEC_LO: addr = VEC_LO;
      ADDR_VEC_HI: addr = VEC_HI;
      ADDR_ZP:     addr = {8'h00, rd_data};
      ADDR_ABS:    addr = {rd_data, op_lo};
      default:     addr = pc;
    endcase
  end

  assign addr_ram = (addr <= RAM_TOP);
  assign addr_rom = (addr >= ROM_BASE);

  always_comb begin
    case (cmd.reg_sel)
      SEL_A:   wr_data = acc;
      SEL_X:   wr_data = xr;
      SEL_Y:   wr_data = yr;
      default: wr_data = acc;
    endcase
  end

  assign rd_data = q_is_ram ? ram_q : (q_is_rom ? rom_q : 8'hFF);

  // RAM: clearing pass after reset, then bus writes
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      ram[clr_addr] <= 8'h00;
    end else if (cmd.mem_wr && addr_ram) begin
      ram[addr[RAM_AW-1:0]] <= wr_data;
    end
    if (cmd.mem_rd) begin
      ram_q <= ram[addr[RAM_AW-1:0]];
    end
  end

  // ROM: bit 15 of the bus address drops out of the offset
  always_ff @(posedge clk) begin
    if (cmd.rom_load) begin
      rom[load_address[ROM_AW-1:0]] <= load_data;
    end
    if (cmd.mem_rd) begin
      rom_q <= rom[addr[ROM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_is_ram <= 1'b0;
      q_is_rom <= 1'b0;
    end else if (cmd.mem_rd) begin
      q_is_ram <= addr_ram;
      q_is_rom <= addr_rom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      acc       <= '0;
      xr        <= '0;
      yr        <= '0;
      halt      <= 1'b0;
      opcode    <= '0;
      stat_code <= STAT_OK;
    end else begin
      if (cmd.pc_load_vec) begin
        pc <= {rd_data, op_lo};
      end else if (cmd.pc_inc) begin
        pc <= pc + 16'd1;
      end
      if (cmd.reg_load) begin
        case (cmd.reg_sel)
          SEL_A:   acc <= rd_data;
          SEL_X:   xr  <= rd_data;
          SEL_Y:   yr  <= rd_data;
          default: acc <= rd_data;
        endcase
      end
      if (cmd.halt_set) begin
        halt <= 1'b1;
      end else if (cmd.halt_clr) begin
        halt <= 1'b0;
      end
      if (cmd.op_capture) begin
        opcode <= rd_data;
      end
      if (cmd.mem_wr) begin
        if (addr_ram) begin
          stat_code <= STAT_OK;
        end else if (addr_rom) begin
          stat_code <= STAT_ROM_WR;
        end else begin
          stat_code <= STAT_UNMAPPED;
        end
      end else if (cmd.status_wr) begin
        stat_code <= cmd.status_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lo_capture) begin
      op_lo <= rd_data;
    end
  end

  // result word snapshot
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      program_counter <= pc;
      accumulator     <= acc;
      index_x         <= xr;
      index_y         <= yr;
      halted          <= halt;
      status          <= 3'(stat_code);
      last_opcode     <= opcode;
    end
  end

  assign stat.clear_last = (clr_addr == RAM_AW'(RAM_DEPTH - 1));
  assign stat.halted     = halt;
  assign stat.rd_data    = rd_data;
  assign stat.opcode     = opcode;

endmodule

// ===== rtl/c6502_ctrl.sv =====
module c6502_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  output logic                out_valid,
  input  logic                out_stall,
  output c6502_pkg::dp_cmd_t  cmd,
  input  c6502_pkg::dp_stat_t stat
);
  import c6502_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;
  func_t  fn;

  assign fn       = func_t'(func);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (fn)
            FUNC_RESET: state_next = S_VEC_LO;
            FUNC_EXEC:  state_next = stat.halted ? S_DONE : S_OPCODE;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_VEC_LO: state_next = S_VEC_HI;
      S_VEC_HI: state_next = S_DONE;
      S_OPCODE: begin
        case (stat.rd_data)
          OP_LDA_IMM, OP_LDX_IMM, OP_LDY_IMM, OP_LDA_ZP, OP_LDA_ABS,
          OP_STA_ZP, OP_STX_ZP, OP_STY_ZP, OP_STA_ABS, OP_STX_ABS,
          OP_STY_ABS: state_next = S_OPER1;
          default:    state_next = S_DONE;
        endcase
      end
      S_OPER1: begin
        case (stat.opcode)
          OP_LDA_ZP:                          state_next = S_DATA;
          OP_LDA_ABS, OP_STA_ABS, OP_STX_ABS,
          OP_STY_ABS:                         state_next = S_OPER2;
          default:                            state_next = S_DONE;
        endcase
      end
      S_OPER2: begin
        state_next = (stat.opcode == OP_LDA_ABS) ? S_DATA : S_DONE;
      end
      S_DATA: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.addr_sel    = ADDR_PC;
    cmd.reg_sel     = SEL_A;
    cmd.status_code = STAT_OK;
    case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        if (accept) begin
          cmd.status_wr = 1'b1;
          case (fn)
            FUNC_LOAD: cmd.rom_load = 1'b1;
            FUNC_RESET: begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = ADDR_VEC_LO;
            end
            FUNC_EXEC: begin
              if (stat.halted) begin
                cmd.status_code = STAT_HALTED;
              end else begin
                cmd.mem_rd = 1'b1;
                cmd.pc_inc = 1'b1;
              end
            end
            default: cmd.status_code = STAT_OK;
          endcase
        end
      end
      S_VEC_LO: begin
        cmd.lo_capture = 1'b1;
        cmd.mem_rd     = 1'b1;
        cmd.addr_sel   = ADDR_VEC_HI;
      end
      S_VEC_HI: begin
        cmd.pc_load_vec = 1'b1;
        cmd.halt_clr    = 1'b1;
      end
      S_OPCODE: begin
        cmd.op_capture = 1'b1;
        case (stat.rd_data)
          OP_HLT: cmd.halt_set = 1'b1;
          OP_LDA_IMM, OP_LDX_IMM, OP_LDY_IMM, OP_LDA_ZP, OP_LDA_ABS,
          OP_STA_ZP, OP_STX_ZP, OP_STY_ZP, OP_STA_ABS, OP_STX_ABS,
          OP_STY_ABS: begin
            cmd.mem_rd = 1'b1;
            cmd.pc_inc = 1'b1;
          end
          default: begin
            cmd.halt_set    = 1'b1;
            cmd.status_wr   = 1'b1;
            cmd.status_code = STAT_UNKNOWN_OP;
          end
        endcase
      end
      S_OPER1: begin
        case (stat.opcode)
          OP_LDA_IMM: begin
            cmd.reg_load = 1'b1;
            cmd.reg_sel  = SEL_A;
          end
          OP_LDX_IMM: begin
            cmd.reg_load = 1'b1;
            cmd.reg_sel  = SEL_X;
          end
          OP_LDY_IMM: begin
            cmd.reg_load = 1'b1;
            cmd.reg_sel  = SEL_Y;
          end
          OP_LDA_ZP: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_ZP;
          end
          OP_STA_ZP: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADDR_ZP;
            cmd.reg_sel  = SEL_A;
          end
          OP_STX_ZP: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADDR_ZP;
            cmd.reg_sel  = SEL_X;
          end
          OP_STY_ZP: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADDR_ZP;
            cmd.reg_sel  = SEL_Y;
          end
          default: begin
            // absolute: hold low byte, fetch high byte
            cmd.lo_capture = 1'b1;
            cmd.mem_rd     = 1'b1;
            cmd.pc_inc     = 1'b1;
          end
        endcase
      end
      S_OPER2: begin
        cmd.addr_sel = ADDR_ABS;
        case (stat.opcode)
          OP_LDA_ABS: cmd.mem_rd = 1'b1;
          OP_STX_ABS: begin
            cmd.mem_wr  = 1'b1;
            cmd.reg_sel = SEL_X;
          end
          OP_STY_ABS: begin
            cmd.mem_wr  = 1'b1;
            cmd.reg_sel = SEL_Y;
          end
          default: begin
            cmd.mem_wr  = 1'b1;
            cmd.reg_sel = SEL_A;
          end
        endcase
      end
      S_DATA: begin
        cmd.reg_load = 1'b1;
        cmd.reg_sel  = SEL_A;
      end
      S_DONE: cmd.out_load = out_free;
      default: cmd.out_load = 1'b0;
    endcase
  end

endmodule

// ===== rtl/cpu_6502_load_store_subset.sv =====
// Loads, halted steps, idle codes, vector resets and instructions (absolute LDA the longest)
// each run to completion; one item executes at a time.
// Memory accesses go through the single bus port with registered read data.
// The next item is taken while the previous result word still waits at the output.
// Reset (rst, synchronous) clears the core registers, then sweeps every word of work RAM
// to zero with in_stall high; program ROM is not cleared.
module cpu_6502_load_store_subset #(
  parameter int RAM_DEPTH = 2048,
  parameter int ROM_DEPTH = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [14:0] load_address,
  input  logic [7:0]  load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] program_counter,
  output logic [7:0]  accumulator,
  output logic [7:0]  index_x,
  output logic [7:0]  index_y,
  output logic        halted,
  output logic [2:0]  status,
  output logic [7:0]  last_opcode
);
  import c6502_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  c6502_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  c6502_dp #(
    .RAM_DEPTH (RAM_DEPTH),
    .ROM_DEPTH (ROM_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .load_address    (load_address),
    .load_data       (load_data),
    .program_counter (program_counter),
    .accumulator     (accumulator),
    .index_x         (index_x),
    .index_y         (index_y),
    .halted          (halted),
    .status          (status),
    .last_opcode     (last_opcode)
  );

endmodule

// ===== sim/tb_cpu_6502_load_store_subset.sv =====
`timescale 1ns / 1ps

module tb_cpu_6502_load_store_subset;
  import c6502_pkg::*;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        halt;
    stat_code_t  st;
    logic [7:0]  op;
  } regs_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = 2'd0;
  logic [14:0] load_address = 15'd0;
  logic [7:0]  load_data = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] program_counter;
  logic [7:0]  accumulator;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic        halted;
  logic [2:0]  status;
  logic [7:0]  last_opcode;

  // predicted core state
  logic [15:0] cpu_pc = 16'd0;
  logic [7:0]  cpu_a = 8'd0;
  logic [7:0]  cpu_x = 8'd0;
  logic [7:0]  cpu_y = 8'd0;
  logic        cpu_halt = 1'b0;
  logic [7:0]  cpu_op = 8'd0;
  bit [7:0]    ram_img [2048];
  bit [7:0]    rom_img [32768];
  bit          rom_loaded [32768];

  regs_word_t  pending_regs [$];
  int          items_sent = 0;
  int          mismatch_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  cpu_6502_load_store_subset uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .load_address    (load_address),
    .load_data       (load_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .program_counter (program_counter),
    .accumulator     (accumulator),
    .index_x         (index_x),
    .index_y         (index_y),
    .halted          (halted),
    .status          (status),
    .last_opcode     (last_opcode)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] bus_peek(logic [15:0] a);
    if (a <= RAM_TOP) return ram_img[a[10:0]];
    if (a >= ROM_BASE) return rom_img[a[14:0]];
    return 8'hFF;
  endfunction

  function automatic stat_code_t bus_poke(logic [15:0] a, logic [7:0] v);
    if (a <= RAM_TOP) begin
      ram_img[a[10:0]] = v;
      return STAT_OK;
    end
    if (a >= ROM_BASE) return STAT_ROM_WR;
    return STAT_UNMAPPED;
  endfunction

  function automatic bit bus_ready(logic [15:0] a);
    return !(a >= ROM_BASE && !rom_loaded[a[14:0]]);
  endfunction

  function automatic logic [7:0] pull_byte();
    logic [7:0] b;
    b = bus_peek(cpu_pc);
    cpu_pc = cpu_pc + 16'd1;
    return b;
  endfunction

  function automatic logic [15:0] pull_word();
    logic [7:0] lo;
    lo = pull_byte();
    return {pull_byte(), lo};
  endfunction

  // -1 marks an opcode the core does not know
  function automatic int operand_bytes(logic [7:0] op);
    case (op)
      OP_HLT: return 0;
      OP_LDA_IMM, OP_LDX_IMM, OP_LDY_IMM, OP_LDA_ZP,
      OP_STA_ZP, OP_STX_ZP, OP_STY_ZP: return 1;
      OP_LDA_ABS, OP_STA_ABS, OP_STX_ABS, OP_STY_ABS: return 2;
      default: return -1;
    endcase
  endfunction

  function automatic regs_word_t predict_regs(func_t f, logic [14:0] la, logic [7:0] ld);
    regs_word_t w;
    logic [7:0] op;
    stat_code_t st;
    st = STAT_OK;
    case (f)
      FUNC_LOAD: begin
        rom_img[la] = ld;
        rom_loaded[la] = 1'b1;
      end
      FUNC_RESET: begin
        cpu_pc = {bus_peek(VEC_HI), bus_peek(VEC_LO)};
        cpu_halt = 1'b0;
      end
      FUNC_EXEC: begin
        if (cpu_halt) begin
          st = STAT_HALTED;
        end else begin
          op = pull_byte();
          cpu_op = op;
          case (op)
            OP_HLT:     cpu_halt = 1'b1;
            OP_LDA_IMM: cpu_a = pull_byte();
            OP_LDX_IMM: cpu_x = pull_byte();
            OP_LDY_IMM: cpu_y = pull_byte();
            OP_LDA_ZP:  cpu_a = bus_peek({8'h00, pull_byte()});
            OP_LDA_ABS: cpu_a = bus_peek(pull_word());
            OP_STA_ZP:  st = bus_poke({8'h00, pull_byte()}, cpu_a);
            OP_STX_ZP:  st = bus_poke({8'h00, pull_byte()}, cpu_x);
            OP_STY_ZP:  st = bus_poke({8'h00, pull_byte()}, cpu_y);
            OP_STA_ABS: st = bus_poke(pull_word(), cpu_a);
            OP_STX_ABS: st = bus_poke(pull_word(), cpu_x);
            OP_STY_ABS: st = bus_poke(pull_word(), cpu_y);
            default: begin
              cpu_halt = 1'b1;
              st = STAT_UNKNOWN_OP;
            end
          endcase
        end
      end
      default: ;
    endcase
    w.pc = cpu_pc;
    w.a = cpu_a;
    w.x = cpu_x;
    w.y = cpu_y;
    w.halt = cpu_halt;
    w.st = st;
    w.op = cpu_op;
    return w;
  endfunction

  // ROM offset that the next instruction would read before it is loaded, else -1
  function automatic int unloaded_read();
    logic [15:0] p, q, ea;
    logic [7:0] op;
    int i, n;
    if (cpu_halt) return -1;
    p = cpu_pc;
    if (!bus_ready(p)) return int'(p[14:0]);
    op = bus_peek(p);
    n = operand_bytes(op);
    for (i = 1; i <= n; i++) begin
      q = p + 16'(i);
      if (!bus_ready(q)) return int'(q[14:0]);
    end
    if (op == OP_LDA_ABS) begin
      ea = {bus_peek(p + 16'd2), bus_peek(p + 16'd1)};
      if (!bus_ready(ea)) return int'(ea[14:0]);
    end
    return -1;
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 16'h1FFF));
      1: return 16'($urandom_range(0, 16'h00FF));
      2: return 16'($urandom_range(16'h2000, 16'h7FFF));
      3: return 16'($urandom_range(16'h8000, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 6))
          0: return 16'h07FF;
          1: return 16'h0800;
          2: return 16'h1FFF;
          3: return 16'h2000;
          4: return 16'h7FFF;
          5: return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  task automatic flag_field(string name, logic [15:0] want_v, logic [15:0] seen_v);
    if (want_v !== seen_v) begin
      mismatch_count++;
      $display("%0t %s expected %h actual %h", $time, name, want_v, seen_v);
    end
  endtask

  always @(posedge clk) begin
    regs_word_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen = {program_counter, accumulator, index_x, index_y, halted, status, last_opcode};
      if (pending_regs.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected word expected none actual %h", $time, seen);
      end else begin
        want = pending_regs.pop_front();
        flag_field("program_counter", want.pc, seen.pc);
        flag_field("accumulator", want.a, seen.a);
        flag_field("index_x", want.x, seen.x);
        flag_field("index_y", want.y, seen.y);
        flag_field("halted", want.halt, seen.halt);
        flag_field("status", want.st, seen.st);
        flag_field("last_opcode", want.op, seen.op);
      end
    end
  end

  task automatic send_item(func_t f, logic [14:0] la, logic [7:0] ld);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    load_address <= la;
    load_data <= ld;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_regs.push_back(predict_regs(f, la, ld));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_regs.size() != 0) @(posedge clk);
  endtask

  // load any ROM byte the next instruction would read, then run it
  task automatic exec_step();
    int hole;
    hole = unloaded_read();
    while (hole >= 0) begin
      send_item(FUNC_LOAD, 15'(hole), 8'($urandom));
      hole = unloaded_read();
    end
    send_item(FUNC_EXEC, 15'($urandom), 8'($urandom));
  endtask

  task automatic test_power_up_state();
    // cleared RAM at address zero decodes as an unknown opcode
    send_item(FUNC_EXEC, 15'h7FFF, 8'hFF);
    send_item(FUNC_EXEC, 15'h0000, 8'h00);
    send_item(FUNC_NONE, 15'h7FFF, 8'hFF);
  endtask

  task automatic test_wrapping_program();
    logic [7:0] prog [$];
    int i;
    // code runs from 0xFFF4 across the vector bytes and wraps into RAM
    prog = {OP_LDA_IMM, OP_HLT, OP_STA_ZP, 8'h00, OP_STA_ABS, 8'h00, 8'h40,
            OP_STY_ABS, 8'hF4, 8'hFF, OP_LDX_IMM, 8'h7F};
    for (i = 0; i < prog.size(); i++)
      send_item(FUNC_LOAD, 15'h7FF4 + 15'(i), prog[i]);
    send_item(FUNC_LOAD, 15'h0000, 8'hFF);
    send_item(FUNC_RESET, 15'h5555, 8'hAA);
    for (i = 0; i < 7; i++)
      send_item(FUNC_EXEC, 15'($urandom), 8'($urandom));
  endtask

  task automatic run_random_program();
    logic [15:0] base, tgt;
    logic [7:0] code [$];
    logic [7:0] op;
    int n, i, steps;
    code = {};
    n = $urandom_range(1, 8);
    base = 16'h8000 | 16'($urandom);
    for (i = 0; i < n; i++) begin
      do op = 8'($urandom); while (operand_bytes(op) <= 0);
      code.push_back(op);
      if (operand_bytes(op) == 1) begin
        code.push_back(8'($urandom));
      end else begin
        tgt = pick_target();
        code.push_back(tgt[7:0]);
        code.push_back(tgt[15:8]);
      end
    end
    case ($urandom_range(0, 3))
      0, 1: code.push_back(OP_HLT);
      2: begin
        do op = 8'($urandom); while (operand_bytes(op) >= 0);
        code.push_back(op);
      end
      default: ;
    endcase
    for (i = 0; i < code.size(); i++)
      send_item(FUNC_LOAD, 15'(base + 16'(i)), code[i]);
    // now and then start from RAM or unmapped space instead
    if ($urandom_range(0, 15) == 0) base = 16'($urandom_range(0, 16'h7FFF));
    send_item(FUNC_LOAD, 15'h7FFC, base[7:0]);
    send_item(FUNC_LOAD, 15'h7FFD, base[15:8]);
    send_item(FUNC_RESET, 15'($urandom), 8'($urandom));
    steps = n + $urandom_range(1, 3);
    for (i = 0; i < steps; i++) begin
      case ($urandom_range(0, 29))
        0: send_item(FUNC_NONE, 15'($urandom), 8'($urandom));
        1: send_item(FUNC_LOAD, 15'($urandom), 8'($urandom));
        2: send_item(FUNC_RESET, 15'($urandom), 8'($urandom));
        default: ;
      endcase
      exec_step();
    end
    if ($urandom_range(0, 7) == 0) drain_results();
  endtask

  task automatic test_random_programs(int sender_idle, int recv_stall, int count);
    int target;
    idle_pct = sender_idle;
    stall_pct = recv_stall;
    target = items_sent + count;
    while (items_sent < target) run_random_program();
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_power_up_state();
    test_wrapping_program();
    test_random_programs(0, 0, 200);
    test_random_programs(55, 0, 200);
    test_random_programs(0, 55, 200);
    test_random_programs(26, 26, 200);
    drain_results();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && pending_regs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
